// ----- rtl/rnas_pkg.sv -----
`timescale 1ns / 1ps

package rnas_pkg;

    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    typedef enum logic [1:0] {
        OP_NORM = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_CMP  = 2'd3
    } opcode_t;

    // Which fraction the reduction unit works on.
    typedef enum logic [1:0] {
        SRC_A = 2'd0,
        SRC_B = 2'd1,
        SRC_R = 2'd2
    } src_t;

    typedef struct packed {
        logic load;
        logic rload;
        src_t src;
        logic g_start;
        logic euc_start;
        logic euc_wr;
        logic qn_wr;
        logic qd_wr;
        logic store;
        logic mul;
        logic sum;
        logic out_load;
    } rnas_cmd_t;

    typedef struct packed {
        logic    err;
        opcode_t op;
        logic    xy_zero;
        logic    div_done;
        logic    div_busy;
    } rnas_sts_t;

endpackage

// ----- rtl/rational_normalize_add_sub.sv -----
`timescale 1ns / 1ps

// Rational arithmetic with gcd reduction: one operation on two signed fractions
// per input beat, one reduced fraction per output beat.
// Input channel (in_valid/in_ready): opcode, a_num, a_den, b_num, b_den.
//   opcode: normalize A, add A+B, subtract A-B, equality compare.
// Output channel (out_valid/out_ready): res_num, res_den, is_equal, zero_den_error.
// Pace: a single shared restoring divider (2*OPERAND_WIDTH bits, one quotient
// bit per cycle) sets the pace of the engine.
// Reducing one fraction takes k + 2 divisions, where k is the
// number of Euclid remainder steps (data dependent, small for typical values).
// Normalize reduces A; compare reduces A and B; add and subtract reduce A, B and
// the cross-multiplied result, which a product step and a sum step form first.
// Zero denominators are caught in the cycle after accept and go straight to the result.
// One item is in work at a time; the next beat is accepted as soon as the result
// moves into the output register, even while that register waits for out_ready.
// A stalled receiver holds out_valid and the result; the engine then waits in its
// final state with in_ready low.
// Reset (rst_n, asynchronous, active low) returns to idle with no result pending.

module rational_normalize_add_sub
    import rnas_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [RES_NUM_W-1:0]     res_num,
    output logic [RES_DEN_W-1:0]            res_den,
    output logic                            is_equal,
    output logic                            zero_den_error
);

    rnas_cmd_t cmd;
    rnas_sts_t sts;

    // Sequencer: walks Euclid, the two gcd divisions and the cross products.
    rnas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Operand capture, reduction registers, divider, multipliers, result register.
    rnas_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .res_num        (res_num),
        .res_den        (res_den),
        .is_equal       (is_equal),
        .zero_den_error (zero_den_error)
    );

endmodule

// ----- rtl/rnas_div.sv -----
`timescale 1ns / 1ps

module rnas_div
    import rnas_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quot,
    output logic [WIDTH-1:0] rem
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dsr_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg && !done_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !done_reg)
        else $error("divider done while still running");
`endif

endmodule

// ----- rtl/rnas_dp.sv -----
`timescale 1ns / 1ps

module rnas_dp
    import rnas_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rnas_cmd_t                      cmd,
    output rnas_sts_t                      sts,
    input  logic [1:0]                     opcode,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic signed [RES_NUM_W-1:0]    res_num,
    output logic [RES_DEN_W-1:0]           res_den,
    output logic                           is_equal,
    output logic                           zero_den_error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int SW = PW + 1;
    localparam int XN = (SW > RES_NUM_W) ? SW : RES_NUM_W;
    localparam int XD = (PW > RES_DEN_W) ? PW : RES_DEN_W;

    // Captured operands
    opcode_t               op_reg;
    logic                  err_reg;
    logic signed [W-1:0]   an_reg;
    logic signed [W-1:0]   ad_reg;
    logic signed [W-1:0]   bn_reg;
    logic signed [W-1:0]   bd_reg;

    // Reduction unit
    logic [PW-1:0]         mn_reg;
    logic [PW-1:0]         md_reg;
    logic                  neg_reg;
    logic [PW-1:0]         x_reg;
    logic [PW-1:0]         y_reg;
    logic [PW-1:0]         g_reg;
    logic                  x_sel_reg;

    // Reduced operands
    logic [W-1:0]          ra_mag_reg;
    logic [W-1:0]          ra_den_reg;
    logic                  ra_neg_reg;
    logic [W-1:0]          rb_mag_reg;
    logic [W-1:0]          rb_den_reg;
    logic                  rb_neg_reg;

    // Cross products and raw sum
    logic [PW-1:0]         pl_reg;
    logic [PW-1:0]         pr_reg;
    logic [PW-1:0]         pd_reg;
    logic signed [SW-1:0]  rn_reg;
    logic [PW-1:0]         rd_reg;

    // Result beat
    logic signed [RES_NUM_W-1:0] res_num_reg;
    logic [RES_DEN_W-1:0]        res_den_reg;
    logic                        is_equal_reg;
    logic                        zero_den_error_reg;

    logic signed [SW-1:0]  src_n;
    logic signed [SW-1:0]  src_d;
    logic signed [SW-1:0]  n_abs;
    logic signed [SW-1:0]  d_abs;
    logic                  n_zero;
    logic [PW-1:0]         ld_md;
    logic                  ld_neg;
    logic                  x_gt;
    logic                  div_start;
    logic [PW-1:0]         div_dvd;
    logic [PW-1:0]         div_dsr;
    logic                  div_busy;
    logic                  div_done;
    logic [PW-1:0]         div_quot;
    logic [PW-1:0]         div_rem;
    logic                  r_neg;
    logic signed [SW-1:0]  sl;
    logic signed [SW-1:0]  sr;
    logic signed [SW-1:0]  res_full;
    logic signed [XN-1:0]  res_ext;
    logic [XD-1:0]         den_ext;
    logic                  frac_eq;

    // Pick the fraction to reduce and fold the denominator sign into the numerator.
    always_comb
    begin
        case (cmd.src)
            SRC_A:
            begin
                src_n = SW'(an_reg);
                src_d = SW'(ad_reg);
            end
            SRC_B:
            begin
                src_n = SW'(bn_reg);
                src_d = SW'(bd_reg);
            end
            default:
            begin
                src_n = rn_reg;
                src_d = SW'({1'b0, rd_reg});
            end
        endcase
    end

    assign n_zero = (src_n == '0);
    assign n_abs  = src_n[SW-1] ? -src_n : src_n;
    assign d_abs  = src_d[SW-1] ? -src_d : src_d;
    assign ld_md  = n_zero ? PW'(1) : d_abs[PW-1:0];
    assign ld_neg = !n_zero && (src_n[SW-1] ^ src_d[SW-1]);

    assign x_gt = (x_reg > y_reg);

    // Divider operands: Euclid remainder, then numerator and denominator over gcd.
    assign div_start = cmd.g_start | cmd.euc_start | cmd.qn_wr;

    always_comb
    begin
        if (cmd.g_start)
        begin
            div_dvd = mn_reg;
            div_dsr = x_reg + y_reg;
        end
        else if (cmd.qn_wr)
        begin
            div_dvd = md_reg;
            div_dsr = g_reg;
        end
        else
        begin
            div_dvd = x_gt ? x_reg : y_reg;
            div_dsr = x_gt ? y_reg : x_reg;
        end
    end

    rnas_div #(
        .WIDTH (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign r_neg = rb_neg_reg ^ (op_reg == OP_SUB);
    assign sl    = ra_neg_reg ? -SW'(pl_reg) : SW'(pl_reg);
    assign sr    = r_neg ? -SW'(pr_reg) : SW'(pr_reg);

    assign res_full = neg_reg ? -SW'(mn_reg) : SW'(mn_reg);
    assign res_ext  = XN'(res_full);
    assign den_ext  = XD'(md_reg);
    assign frac_eq  = (ra_neg_reg == rb_neg_reg) && (ra_mag_reg == rb_mag_reg)
                      && (ra_den_reg == rb_den_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(opcode);
            err_reg <= (a_den == '0) || ((opcode_t'(opcode) != OP_NORM) && (b_den == '0));
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end

        if (cmd.rload)
        begin
            mn_reg  <= n_abs[PW-1:0];
            md_reg  <= ld_md;
            neg_reg <= ld_neg;
            x_reg   <= n_abs[PW-1:0];
            y_reg   <= ld_md;
        end

        if (cmd.g_start)
        begin
            g_reg <= x_reg + y_reg;
        end

        if (cmd.euc_start)
        begin
            x_sel_reg <= x_gt;
        end

        if (cmd.euc_wr)
        begin
            if (x_sel_reg)
            begin
                x_reg <= div_rem;
            end
            else
            begin
                y_reg <= div_rem;
            end
        end

        if (cmd.qn_wr)
        begin
            mn_reg <= div_quot;
        end

        if (cmd.qd_wr)
        begin
            md_reg <= div_quot;
        end

        if (cmd.store)
        begin
            case (cmd.src)
                SRC_A:
                begin
                    ra_mag_reg <= mn_reg[W-1:0];
                    ra_den_reg <= md_reg[W-1:0];
                    ra_neg_reg <= neg_reg;
                end
                SRC_B:
                begin
                    rb_mag_reg <= mn_reg[W-1:0];
                    rb_den_reg <= md_reg[W-1:0];
                    rb_neg_reg <= neg_reg;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.mul)
        begin
            pl_reg <= PW'(ra_mag_reg) * PW'(rb_den_reg);
            pr_reg <= PW'(rb_mag_reg) * PW'(ra_den_reg);
            pd_reg <= PW'(ra_den_reg) * PW'(rb_den_reg);
        end

        if (cmd.sum)
        begin
            rn_reg <= sl + sr;
            rd_reg <= pd_reg;
        end

        if (cmd.out_load)
        begin
            if (err_reg)
            begin
                res_num_reg        <= '0;
                res_den_reg        <= '0;
                is_equal_reg       <= 1'b0;
                zero_den_error_reg <= 1'b1;
            end
            else
            begin
                case (op_reg)
                    OP_CMP:
                    begin
                        res_num_reg        <= '0;
                        res_den_reg        <= '0;
                        is_equal_reg       <= frac_eq;
                        zero_den_error_reg <= 1'b0;
                    end
                    default:
                    begin
                        res_num_reg        <= res_ext[RES_NUM_W-1:0];
                        res_den_reg        <= den_ext[RES_DEN_W-1:0];
                        is_equal_reg       <= 1'b0;
                        zero_den_error_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign sts.err      = err_reg;
    assign sts.op       = op_reg;
    assign sts.xy_zero  = (x_reg == '0) || (y_reg == '0);
    assign sts.div_done = div_done;
    assign sts.div_busy = div_busy;

    assign res_num        = res_num_reg;
    assign res_den        = res_den_reg;
    assign is_equal       = is_equal_reg;
    assign zero_den_error = zero_den_error_reg;

endmodule

// ----- rtl/rnas_ctrl.sv -----
`timescale 1ns / 1ps

module rnas_ctrl
    import rnas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rnas_sts_t sts,
    output rnas_cmd_t cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CHECK = 12'b000000000010,
        S_EUC   = 12'b000000000100,
        S_EDIV  = 12'b000000001000,
        S_QN    = 12'b000000010000,
        S_QD    = 12'b000000100000,
        S_STORE = 12'b000001000000,
        S_LDB   = 12'b000010000000,
        S_MUL   = 12'b000100000000,
        S_SUM   = 12'b001000000000,
        S_LDR   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    src_t   src_reg;
    src_t   src_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.src        = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.err)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rload  = 1'b1;
                    cmd.src    = SRC_A;
                    src_next   = SRC_A;
                    state_next = S_EUC;
                end
            end
            S_EUC:
            begin
                if (sts.xy_zero)
                begin
                    cmd.g_start = 1'b1;
                    state_next  = S_QN;
                end
                else
                begin
                    cmd.euc_start = 1'b1;
                    state_next    = S_EDIV;
                end
            end
            S_EDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.euc_wr = 1'b1;
                    state_next = S_EUC;
                end
            end
            S_QN:
            begin
                if (sts.div_done)
                begin
                    cmd.qn_wr  = 1'b1;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                if (sts.div_done)
                begin
                    cmd.qd_wr  = 1'b1;
                    state_next = (src_reg == SRC_R) ? S_DONE : S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (src_reg == SRC_A)
                begin
                    state_next = (sts.op == OP_NORM) ? S_DONE : S_LDB;
                end
                else
                begin
                    state_next = (sts.op == OP_CMP) ? S_DONE : S_MUL;
                end
            end
            S_LDB:
            begin
                cmd.rload  = 1'b1;
                cmd.src    = SRC_B;
                src_next   = SRC_B;
                state_next = S_EUC;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_LDR;
            end
            S_LDR:
            begin
                cmd.rload  = 1'b1;
                cmd.src    = SRC_R;
                src_next   = SRC_R;
                state_next = S_EUC;
            end
            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_reg       <= SRC_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !sts.div_busy)
        else $error("input beat taken while divider is running");
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_EDIV || state_reg == S_QN || state_reg == S_QD))
        else $error("divider finished outside a wait state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (!sts.err && (sts.op == OP_ADD || sts.op == OP_SUB)))
        else $error("cross multiply for an operation that has none");
`endif

endmodule

// ----- verif/tb_rational_normalize_add_sub.sv -----
`timescale 1ns / 1ps

// Each beat on the input channel carries one operation on two signed fractions.
// The bench predicts the reduced fraction for every accepted beat and compares it,
// field by field, with the next beat on the output channel.

module tb_rational_normalize_add_sub
    import rnas_pkg::*;
();

    localparam int OPW = 16;
    localparam logic signed [OPW-1:0] OPND_MAX = 16'sh7fff;
    localparam logic signed [OPW-1:0] OPND_MIN = 16'sh8000;

    // One output beat as the block should present it.
    typedef struct packed {
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        logic                 eq;
        logic                 err;
    } frac_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               opcode;
    logic signed [OPW-1:0]    a_num;
    logic signed [OPW-1:0]    a_den;
    logic signed [OPW-1:0]    b_num;
    logic signed [OPW-1:0]    b_den;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]     res_den;
    logic                     is_equal;
    logic                     zero_den_error;

    // Reduced fractions still owed by the block, oldest first.
    frac_result_t pending_fracs[$];

    int  fail_count;
    int  beats_checked;
    int  sent_by_op[4];
    int  zero_den_seen;
    int  equal_seen;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_hold;

    rational_normalize_add_sub #(.OPERAND_WIDTH(OPW)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .res_num        (res_num),
        .res_den        (res_den),
        .is_equal       (is_equal),
        .zero_den_error (zero_den_error)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #400_000_000;
        $display("tb_rational_normalize_add_sub failed");
        $finish;
    end

    // Move the sign into the numerator, force 0/1, then divide out the gcd.
    function automatic void reduce_frac(inout longint n, inout longint d);
        longint unsigned mn, md, x, y, g;
        bit              neg;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n == 0)
            d = 1;
        neg = n < 0;
        mn = neg ? -n : n;
        md = d;
        x = mn;
        y = md;
        while (x > 0 && y > 0)
        begin
            if (x > y)
                x = x % y;
            else
                y = y % x;
        end
        g = x + y;
        if (g == 0)
            g = 1;
        mn = mn / g;
        md = md / g;
        n = neg ? -longint'(mn) : longint'(mn);
        d = longint'(md);
    endfunction

    function automatic frac_result_t rational_result(opcode_t op,
                                                     logic signed [OPW-1:0] an_i,
                                                     logic signed [OPW-1:0] ad_i,
                                                     logic signed [OPW-1:0] bn_i,
                                                     logic signed [OPW-1:0] bd_i);
        longint       an, ad, bn, bd, rn, rd;
        frac_result_t r;
        an = an_i;
        ad = ad_i;
        bn = bn_i;
        bd = bd_i;
        rn = 0;
        rd = 0;
        r  = '0;
        // Normalize looks only at A's denominator; the rest use both.
        if (ad == 0 || (op != OP_NORM && bd == 0))
            r.err = 1'b1;
        else
        begin
            reduce_frac(an, ad);
            if (op != OP_NORM)
                reduce_frac(bn, bd);
            case (op)
                OP_NORM:
                begin
                    rn = an;
                    rd = ad;
                end
                OP_CMP:
                    r.eq = (an == bn) && (ad == bd);
                default:
                begin
                    rn = (op == OP_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
                    rd = ad * bd;
                    reduce_frac(rn, rd);
                end
            endcase
        end
        r.num = rn[RES_NUM_W-1:0];
        r.den = rd[RES_DEN_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [OPW-1:0] rand_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 4))
                0: return OPND_MIN;
                1: return OPND_MAX;
                2: return -1;
                3: return 1;
                default: return 0;
            endcase
        end
        // Keep most values small so the remainder loop stays short.
        if (r < 55)
            return OPW'($urandom_range(0, 600) - 300);
        return OPW'($urandom);
    endfunction

    function automatic logic signed [OPW-1:0] rand_den();
        if ($urandom_range(0, 99) < 3)
            return 0;
        return rand_operand();
    endfunction

    // Offer one beat at a falling edge, hold it until accepted, then maybe idle a while.
    task automatic send_item(opcode_t op, logic signed [OPW-1:0] an,
                             logic signed [OPW-1:0] ad, logic signed [OPW-1:0] bn,
                             logic signed [OPW-1:0] bd);
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        do
            @(posedge clk);
        while (!in_ready);
        pending_fracs.push_back(rational_result(op, an, ad, bn, bd));
        sent_by_op[op]++;
        @(negedge clk);
        gap = pick_gap(tx_idle_en);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic test_directed();
        // Normalize: sign move, most negative operand, zero numerator, zero denominator.
        send_item(OP_NORM, 6, -4, 0, 0);
        send_item(OP_NORM, OPND_MIN, OPND_MIN, 0, 0);
        send_item(OP_NORM, OPND_MAX, -1, 0, 0);
        send_item(OP_NORM, 0, -7, 0, 0);
        send_item(OP_NORM, 5, 0, 1, 1);
        send_item(OP_NORM, 3, 9, 2, 0);
        send_item(OP_NORM, OPND_MIN, 1, 0, 0);
        send_item(OP_NORM, -1, OPND_MIN, 0, 0);
        // Add: widest sums and products, cancellation, zero B denominator.
        send_item(OP_ADD, OPND_MIN, 1, OPND_MIN, 1);
        send_item(OP_ADD, 1, OPND_MAX, 1, OPND_MIN);
        send_item(OP_ADD, OPND_MAX, OPND_MIN, OPND_MAX, OPND_MIN);
        send_item(OP_ADD, OPND_MIN, OPND_MAX, OPND_MIN, OPND_MAX);
        send_item(OP_ADD, 1, 3, -1, 3);
        send_item(OP_ADD, 2, 5, 3, 0);
        // Subtract.
        send_item(OP_SUB, OPND_MAX, 1, OPND_MIN, 1);
        send_item(OP_SUB, 1, OPND_MIN, 1, OPND_MAX);
        send_item(OP_SUB, 0, 0, 1, 1);
        send_item(OP_SUB, -7, -14, 1, 2);
        // Compare: equal after reduction, sign differs, zeros, extremes, errors.
        send_item(OP_CMP, 2, 4, -1, -2);
        send_item(OP_CMP, 1, 3, 1, -3);
        send_item(OP_CMP, 0, 5, 0, -9);
        send_item(OP_CMP, OPND_MIN, OPND_MIN, OPND_MAX, OPND_MAX);
        send_item(OP_CMP, 1, 1, 1, 0);
        send_item(OP_CMP, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        opcode_t op;
        int      n, d, k;
        for (int i = 0; i < count; i++)
        begin
            op = opcode_t'($urandom_range(0, 3));
            if (op == OP_CMP && $urandom_range(0, 1) == 1)
            begin
                // Build B as a scaled copy of A so equal pairs show up often.
                n = $urandom_range(0, 400) - 200;
                d = $urandom_range(1, 200) * ($urandom_range(0, 1) ? -1 : 1);
                k = $urandom_range(1, 6) * ($urandom_range(0, 1) ? -1 : 1);
                send_item(op, OPW'(n), OPW'(d), OPW'(n * k), OPW'(d * k));
            end
            else
                send_item(op, rand_operand(), rand_den(), rand_operand(), rand_den());
        end
    endtask

    // Both sides at full rate: no gaps from the bench at all.
    task automatic test_full_rate(int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Hold the receiver off for a long stretch while beats keep coming, so the
    // output register fills and the block drops in_ready.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_hold = 2000;
        for (int i = 0; i < 8; i++)
            send_item(opcode_t'(i % 4), OPW'(i * 3 - 5), OPW'(i + 2), OPW'(7 - i),
                      OPW'(-(i + 1)));
        tx_idle_en = 1'b1;
    endtask

    task automatic report_mismatch(string field, longint want, longint got);
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    // Output side: drive out_ready at falling edges, with random stalls and
    // an optional long hold requested by the backpressure test.
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap(rx_idle_en);
            end
        end
    end

    // Check every output beat against the oldest pending fraction.
    always @(posedge clk)
    begin
        frac_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (pending_fracs.size() == 0)
            begin
                $display("%0t ns: output beat with nothing expected, num %0d den %0d",
                         $time, res_num, res_den);
                fail_count++;
            end
            else
            begin
                want = pending_fracs.pop_front();
                if (res_num !== $signed(want.num))
                    report_mismatch("res_num", $signed(want.num), res_num);
                if (res_den !== want.den)
                    report_mismatch("res_den", want.den, res_den);
                if (is_equal !== want.eq)
                    report_mismatch("is_equal", want.eq, is_equal);
                if (zero_den_error !== want.err)
                    report_mismatch("zero_den_error", want.err, zero_den_error);
                zero_den_seen += want.err;
                equal_seen    += want.eq;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_NORM;
        a_num      = '0;
        a_den      = '0;
        b_num      = '0;
        b_den      = '0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold    = 0;
        fail_count = 0;
        beats_checked = 0;
        zero_den_seen = 0;
        equal_seen    = 0;
        foreach (sent_by_op[i])
            sent_by_op[i] = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(1150);
        test_full_rate(150);
        test_backpressure();
        in_valid <= 1'b0;

        // Drain, then let the block sit a while to catch stray output beats.
        while (pending_fracs.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Checked %0d results: %0d normalize, %0d add, %0d subtract, %0d compare.",
                 beats_checked, sent_by_op[OP_NORM], sent_by_op[OP_ADD],
                 sent_by_op[OP_SUB], sent_by_op[OP_CMP]);
        $display("Zero denominators flagged: %0d; compares found equal: %0d.",
                 zero_den_seen, equal_seen);
        if (fail_count == 0)
            $display("tb_rational_normalize_add_sub passed");
        else
            $display("tb_rational_normalize_add_sub failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rnas_pkg.sv
rtl/rnas_div.sv
rtl/rnas_dp.sv
rtl/rnas_ctrl.sv
rtl/rational_normalize_add_sub.sv
verif/tb_rational_normalize_add_sub.sv
